FILE: rtl/rlla_pkg.sv
// Shared types and constants of the route link load accumulator.
`timescale 1ns / 1ps
`default_nettype none

package rlla_pkg;

   localparam int NUM_DIRS = 6;

   localparam logic [2:0] DIR_EAST  = 3'd0;
   localparam logic [2:0] DIR_WEST  = 3'd1;
   localparam logic [2:0] DIR_SOUTH = 3'd2;
   localparam logic [2:0] DIR_NORTH = 3'd3;
   localparam logic [2:0] DIR_UP    = 3'd4;
   localparam logic [2:0] DIR_DOWN  = 3'd5;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_SAME  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_LONG  = 2'd3;

   localparam logic [1:0] CSR_MESH_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MESH_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TIER_COUNT  = 2'd2;
   localparam logic [1:0] CSR_HOP_LIMIT   = 2'd3;

   localparam logic [4:0] HOP_CAP = 5'd17;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_RD,
      S_WB
   } state_type;

   typedef struct packed {
      logic [3:0] mesh_width;
      logic [3:0] mesh_height;
      logic [2:0] tier_count;
      logic [4:0] hop_limit;
   } cfg_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } ram_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/rlla_load_ram.sv
// Single-port link load memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rlla_load_ram #(
   parameter int DEPTH  = 1536,
   parameter int ADDR_W = 11
) (
   input  wire                     clock,
   input  rlla_pkg::ram_ctl_type   ram_ctl,
   input  wire        [ADDR_W-1:0] ram_addr,
   input  wire        [31:0]       ram_wdata,
   output logic       [31:0]       ram_rdata
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_ctl.wr) begin
         mem[ram_addr] <= ram_wdata;
      end
      if (ram_ctl.rd) begin
         rdata_ff <= mem[ram_addr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/rlla_hop_engine.sv
// Request check, hop sequencer, load read-modify-write and result register.
`timescale 1ns / 1ps
`default_nettype none

module rlla_hop_engine #(
   parameter int MAX_COLS  = 8,
   parameter int MAX_ROWS  = 8,
   parameter int MAX_TIERS = 4,
   parameter int DEPTH     = 1536,
   parameter int ADDR_W    = 11
) (
   input  wire                        clock,
   input  wire                        reset,
   input  rlla_pkg::cfg_type          cfg,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire        [39:0]          req_tdata,
   input  wire                        req_tuser,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic       [47:0]          rsp_tdata,
   output logic                       rsp_tlast,
   output rlla_pkg::ram_ctl_type      ram_ctl,
   output logic       [ADDR_W-1:0]    ram_addr,
   output logic       [31:0]          ram_wdata,
   input  wire        [31:0]          ram_rdata
);

   localparam logic [4:0] COLS_LIM  = 5'(MAX_COLS);
   localparam logic [4:0] ROWS_LIM  = 5'(MAX_ROWS);
   localparam logic [3:0] TIERS_LIM = 4'(MAX_TIERS);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [2:0] x, input logic [2:0] y,
                                                   input logic [1:0] z, input logic [2:0] d);
      logic [31:0] idx;
      idx = ((32'(z) * 32'(MAX_ROWS) + 32'(y)) * 32'(MAX_COLS) + 32'(x))
            * 32'(rlla_pkg::NUM_DIRS) + 32'(d);
      return idx[ADDR_W-1:0];
   endfunction

   rlla_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                func_ff, func_in;
   logic [2:0]          sx_ff, sx_in, sy_ff, sy_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [1:0]          sz_ff, sz_in, dz_ff, dz_in;
   logic [15:0]         vol_ff, vol_in;
   logic [2:0]          rdir_ff, rdir_in;
   logic [2:0]          px_ff, px_in, py_ff, py_in;
   logic [1:0]          pz_ff, pz_in;
   logic [2:0]          dir_ff, dir_in;
   logic [4:0]          rem_ff, rem_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [44:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [4:0]  eff_w, eff_h;
   logic [3:0]  eff_t;
   logic        src_in_mesh, dst_in_mesh, same_node, too_long, rd_err, out_free;
   logic [2:0]  nx, ny;
   logic [1:0]  nz;
   logic [4:0]  path_len;
   logic [2:0]  hop_d;
   logic [32:0] sum;
   logic [31:0] new_load;

   assign eff_w = ({1'b0, cfg.mesh_width} < COLS_LIM) ? {1'b0, cfg.mesh_width} : COLS_LIM;
   assign eff_h = ({1'b0, cfg.mesh_height} < ROWS_LIM) ? {1'b0, cfg.mesh_height} : ROWS_LIM;
   assign eff_t = ({1'b0, cfg.tier_count} < TIERS_LIM) ? {1'b0, cfg.tier_count} : TIERS_LIM;

   assign src_in_mesh = ({2'b0, sx_ff} < eff_w) && ({2'b0, sy_ff} < eff_h)
                        && ({2'b0, sz_ff} < eff_t);
   assign dst_in_mesh = ({2'b0, dx_ff} < eff_w) && ({2'b0, dy_ff} < eff_h)
                        && ({2'b0, dz_ff} < eff_t);
   assign same_node   = (sx_ff == dx_ff) && (sy_ff == dy_ff) && (sz_ff == dz_ff);
   assign nx = (sx_ff > dx_ff) ? sx_ff - dx_ff : dx_ff - sx_ff;
   assign ny = (sy_ff > dy_ff) ? sy_ff - dy_ff : dy_ff - sy_ff;
   assign nz = (sz_ff > dz_ff) ? sz_ff - dz_ff : dz_ff - sz_ff;
   assign path_len = 5'(nx) + 5'(ny) + 5'(nz);
   assign too_long = (path_len > cfg.hop_limit) || (path_len > rlla_pkg::HOP_CAP);
   assign rd_err   = !src_in_mesh || (rdir_ff > rlla_pkg::DIR_DOWN);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (px_ff != dx_ff) begin
         hop_d = (dx_ff > px_ff) ? rlla_pkg::DIR_EAST : rlla_pkg::DIR_WEST;
      end else if (py_ff != dy_ff) begin
         hop_d = (dy_ff > py_ff) ? rlla_pkg::DIR_SOUTH : rlla_pkg::DIR_NORTH;
      end else begin
         hop_d = (dz_ff < pz_ff) ? rlla_pkg::DIR_UP : rlla_pkg::DIR_DOWN;
      end
   end

   assign sum      = {1'b0, ram_rdata} + 33'(vol_ff);
   assign new_load = func_ff ? ram_rdata : (sum[32] ? '1 : sum[31:0]);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      func_in      = func_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sz_in        = sz_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      vol_in       = vol_ff;
      rdir_in      = rdir_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      dir_in       = dir_ff;
      rem_in       = rem_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      ram_ctl      = '0;
      ram_addr     = addr_ff;
      ram_wdata    = new_load;

      unique case (state_ff)
         rlla_pkg::S_CLEAR: begin
            ram_ctl.wr = 1'b1;
            ram_addr   = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = rlla_pkg::S_IDLE;
            end
         end
         rlla_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in  = req_tuser;
               sx_in    = req_tdata[2:0];
               sy_in    = req_tdata[5:3];
               sz_in    = req_tdata[7:6];
               dx_in    = req_tdata[10:8];
               dy_in    = req_tdata[13:11];
               dz_in    = req_tdata[15:14];
               vol_in   = req_tdata[31:16];
               rdir_in  = req_tdata[34:32];
               state_in = rlla_pkg::S_CHECK;
            end
         end
         rlla_pkg::S_CHECK: begin
            if (func_ff ? rd_err : (!src_in_mesh || !dst_in_mesh || same_node || too_long)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_data_in  = '0;
                  if (func_ff || !src_in_mesh || !dst_in_mesh) begin
                     rsp_data_in[1:0] = rlla_pkg::STAT_RANGE;
                  end else if (same_node) begin
                     rsp_data_in[1:0] = rlla_pkg::STAT_SAME;
                  end else begin
                     rsp_data_in[1:0] = rlla_pkg::STAT_LONG;
                  end
                  state_in = rlla_pkg::S_IDLE;
               end
            end else begin
               px_in = sx_ff;
               py_in = sy_ff;
               pz_in = sz_ff;
               if (func_ff) begin
                  ram_ctl.rd = 1'b1;
                  ram_addr   = slot_addr(sx_ff, sy_ff, sz_ff, rdir_ff);
                  addr_in    = ram_addr;
                  dir_in     = rdir_ff;
                  rem_in     = 5'd1;
                  state_in   = rlla_pkg::S_WB;
               end else begin
                  rem_in   = path_len;
                  state_in = rlla_pkg::S_RD;
               end
            end
         end
         rlla_pkg::S_RD: begin
            ram_ctl.rd = 1'b1;
            ram_addr   = slot_addr(px_ff, py_ff, pz_ff, hop_d);
            addr_in    = ram_addr;
            dir_in     = hop_d;
            state_in   = rlla_pkg::S_WB;
         end
         rlla_pkg::S_WB: begin
            if (out_free) begin
               ram_ctl.wr   = !func_ff;
               rsp_valid_in = 1'b1;
               rsp_last_in  = (rem_ff == 5'd1);
               rsp_data_in  = {new_load, dir_ff, pz_ff, py_ff, px_ff, rlla_pkg::STAT_OK};
               rem_in       = rem_ff - 1'b1;
               if (rem_ff == 5'd1) begin
                  state_in = rlla_pkg::S_IDLE;
               end else begin
                  state_in = rlla_pkg::S_RD;
                  case (dir_ff)
                     rlla_pkg::DIR_EAST:  px_in = px_ff + 1'b1;
                     rlla_pkg::DIR_WEST:  px_in = px_ff - 1'b1;
                     rlla_pkg::DIR_SOUTH: py_in = py_ff + 1'b1;
                     rlla_pkg::DIR_NORTH: py_in = py_ff - 1'b1;
                     rlla_pkg::DIR_UP:    pz_in = pz_ff - 1'b1;
                     default:             pz_in = pz_ff + 1'b1;
                  endcase
               end
            end
         end
         default: state_in = rlla_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlla_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sz_ff       <= sz_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      vol_ff      <= vol_in;
      rdir_ff     <= rdir_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      dir_ff      <= dir_in;
      rem_ff      <= rem_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/xyz_route_link_load_accumulator.sv
// Top level: configuration registers, hop engine and link load memory.
//
//  channel  | ports                              | payload
//  ---------+------------------------------------+---------------------------------
//  request  | req_tvalid/tready/tdata/tuser      | flow or read request
//  result   | rsp_tvalid/tready/tdata/tlast      | one charged or read link
//  config   | csr_valid/ready/index/wdata        | register writes, always ready
//
// After reset a clearing pass writes zero to every load entry, one per cycle
// (MAX_COLS*MAX_ROWS*MAX_TIERS*6 entries, 1536 at the defaults); no request
// is taken meanwhile. A route is checked, then each hop takes one memory read and
// one write-back through the single memory port; a read skips the write-back.
// A held result stalls the write-back and the error result; a new request is
// taken while the last result of the previous one still waits in the result register.
`timescale 1ns / 1ps
`default_nettype none

module xyz_route_link_load_accumulator #(
   parameter int MAX_COLS  = 8,
   parameter int MAX_ROWS  = 8,
   parameter int MAX_TIERS = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // src_x, src_y, src_z, dst_x, dst_y, dst_z, flow_volume, read_dir
   input  wire  [39:0] req_tdata,
   // func
   input  wire         req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // status, hop_x, hop_y, hop_z, hop_dir, link_load
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [4:0]  csr_wdata
);

   localparam int DEPTH  = MAX_COLS * MAX_ROWS * MAX_TIERS * rlla_pkg::NUM_DIRS;
   localparam int ADDR_W = $clog2(DEPTH);

   rlla_pkg::cfg_type     cfg_ff, cfg_in;
   rlla_pkg::ram_ctl_type ram_ctl;
   logic [ADDR_W-1:0]     ram_addr;
   logic [31:0]           ram_wdata;
   logic [31:0]           ram_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rlla_pkg::CSR_MESH_WIDTH:  cfg_in.mesh_width  = csr_wdata[3:0];
            rlla_pkg::CSR_MESH_HEIGHT: cfg_in.mesh_height = csr_wdata[3:0];
            rlla_pkg::CSR_TIER_COUNT:  cfg_in.tier_count  = csr_wdata[2:0];
            rlla_pkg::CSR_HOP_LIMIT:   cfg_in.hop_limit   = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mesh_width  <= 4'd4;
         cfg_ff.mesh_height <= 4'd4;
         cfg_ff.tier_count  <= 3'd2;
         cfg_ff.hop_limit   <= 5'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlla_hop_engine #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .MAX_TIERS (MAX_TIERS),
      .DEPTH     (DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .ram_ctl    (ram_ctl),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .ram_rdata  (ram_rdata)
   );

   rlla_load_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock     (clock),
      .ram_ctl   (ram_ctl),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

endmodule

`default_nettype wire

FILE: rtl/rlla_checker.sv
// Port-level checks of the accumulator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rlla_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [47:0] rsp_tdata,
   input wire        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in progress");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != rlla_pkg::STAT_OK) |-> rsp_tlast && (rsp_tdata[44:2] == '0))
      else $error("error result not final or not zeroed");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready && !rsp_tvalid)
      else $error("request or result during clearing pass");

endmodule

bind xyz_route_link_load_accumulator rlla_checker u_rlla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
